// ===== rtl/mprp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mprp_pkg
// Shared types and constants of the monochrome pixel row packer.
// ----------------------------------------------------------------------------
package mprp_pkg;

  localparam int MAX_ROW_BYTES_DEF = 16;
  localparam int MAX_ROW_PIXELS    = 128;
  localparam int CFG_INDEX_W       = 2;

  localparam logic [7:0] THRESHOLD_RESET = 8'd128;
  localparam logic [7:0] ROW_WIDTH_RESET = 8'd64;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 2'd1;

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_READ,
    ST_LOAD
  } mprp_state_t;

  typedef struct packed {
    logic pix_take;
    logic rd_en;
    logic out_load;
  } mprp_cmd_t;

  typedef struct packed {
    logic row_end;
    logic rd_last;
  } mprp_status_t;

endpackage
`default_nettype wire

// ===== rtl/mprp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mprp_ctrl
// Sequencer: pixel intake, then per-byte buffer read and output load.
// ----------------------------------------------------------------------------
module mprp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  input  wire mprp_pkg::mprp_status_t status,
  output mprp_pkg::mprp_cmd_t         cmd
);
  import mprp_pkg::*;

  mprp_state_t state;
  mprp_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PIXEL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      ST_PIXEL: begin
        in_stall     = 1'b0;
        cmd.pix_take = in_valid;
        if (in_valid && status.row_end) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = status.rd_last ? ST_PIXEL : ST_READ;
        end
      end
      default: begin
        state_next = ST_PIXEL;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mprp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mprp_datapath
// Config registers, threshold and bit packing, row byte buffer, output register.
// ----------------------------------------------------------------------------
module mprp_datapath #(
  parameter int MAX_ROW_BYTES = mprp_pkg::MAX_ROW_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mprp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [7:0]                         cfg_data,
  input  wire logic [7:0]                         gray_pixel,
  output logic [7:0]                              packed_byte,
  output logic                                    row_last,
  input  wire mprp_pkg::mprp_cmd_t                cmd,
  output mprp_pkg::mprp_status_t                  status
);
  import mprp_pkg::*;

  localparam int IDX_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CAP   = (8 * MAX_ROW_BYTES > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS
                                                             : 8 * MAX_ROW_BYTES;
  localparam logic [7:0]       WIDTH_CAP = 8'(CAP);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_ROW_BYTES - 1);

  logic [7:0]       threshold;
  logic [7:0]       row_width;
  logic [7:0]       group_bits;
  logic [2:0]       group_count;
  logic [6:0]       column;
  logic [IDX_W-1:0] byte_count;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_data;
  logic [7:0]       row_bytes [MAX_ROW_BYTES];

  logic [7:0] eff_width;
  logic [7:0] group_next;
  logic       lit;
  logic       mem_we;

  assign cfg_ready = 1'b1;

  always_comb begin
    eff_width = row_width;
    if (row_width == 8'd0) begin
      eff_width = 8'd1;
    end else if (row_width > WIDTH_CAP) begin
      eff_width = WIDTH_CAP;
    end
  end

  assign lit            = (gray_pixel <= threshold);
  assign group_next     = {group_bits[6:0], lit};
  assign status.row_end = ({1'b0, column} + 8'd1) >= eff_width;
  assign status.rd_last = (rd_idx == '0);
  assign mem_we         = cmd.pix_take && (status.row_end || group_count == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data;
        REG_ROW_WIDTH: row_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits  <= '0;
      group_count <= '0;
      column      <= '0;
      byte_count  <= '0;
      rd_idx      <= '0;
    end else begin
      if (cmd.pix_take) begin
        if (status.row_end) begin
          rd_idx      <= byte_count;
          group_bits  <= '0;
          group_count <= '0;
          column      <= '0;
          byte_count  <= '0;
        end else begin
          column <= column + 7'd1;
          if (group_count == 3'd7) begin
            group_bits  <= '0;
            group_count <= '0;
            if (byte_count != LAST_IDX) begin
              byte_count <= byte_count + 1'b1;
            end
          end else begin
            group_bits  <= group_next;
            group_count <= group_count + 3'd1;
          end
        end
      end
      if (cmd.out_load && !status.rd_last) begin
        rd_idx <= rd_idx - 1'b1;
      end
    end
  end

  // row byte buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_bytes[byte_count] <= group_next;
    end
    if (cmd.rd_en) begin
      rd_data <= row_bytes[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      packed_byte <= rd_data;
      row_last    <= status.rd_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mono_pixel_row_packer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mono_pixel_row_packer_core
// Thresholds gray pixels to 1 bpp, packs them into bytes and emits each row
// last byte first.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while a row fills. A pixel at or below the
// threshold is a lit bit; bits pack first pixel MSB, a partial final group
// stays right-aligned. At a row's last pixel the row buffer drains in reverse
// order, row_last marking the final byte. Each drained byte is a registered
// buffer read, then an output register load, and pixel input is stalled
// until the last byte of the row sits in the output register. cfg_ready is
// held high, so configuration writes are always accepted.
// ----------------------------------------------------------------------------
module mono_pixel_row_packer_core #(
  parameter int MAX_ROW_BYTES = mprp_pkg::MAX_ROW_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mprp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       gray_pixel,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            packed_byte,
  output logic                                  row_last
);
  import mprp_pkg::*;

  mprp_cmd_t    cmd;
  mprp_status_t status;

  mprp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mprp_datapath #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .gray_pixel  (gray_pixel),
    .packed_byte (packed_byte),
    .row_last    (row_last),
    .cmd         (cmd),
    .status      (status)
  );

endmodule
`default_nettype wire

// ===== rtl/mprp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mprp_checker
// Port-level checks of the row packer, bound to the top level.
// ----------------------------------------------------------------------------
module mprp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] packed_byte,
  input wire logic       row_last
);

  // held output transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packed_byte) && $stable(row_last))
    else $error("output payload changed while stalled");

  // no output right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // pixels held off while a row is still draining
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !row_last |-> in_stall)
    else $error("pixel input open before row drain finished");

  // a new byte is only loaded during the drain
  a_load_in_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output loaded outside row drain");

endmodule

bind mono_pixel_row_packer_core mprp_checker u_mprp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .packed_byte (packed_byte),
  .row_last    (row_last)
);
`default_nettype wire
